>>> rtl/dtr_pkg.sv
package dtr_pkg;

	typedef enum logic [1:0] {
		OPC_LINE,
		OPC_TRI,
		OPC_READ,
		OPC_NOP
	} opc_t;

	localparam int CW   = 12;
	localparam int DW   = 8;
	localparam int CNTW = 17;
	localparam int NUMW = 31;
	localparam int DENW = 23;
	localparam int QW   = 8;

	typedef struct packed {
		opc_t                  opcode;
		logic signed [CW-1:0]  first_x;
		logic signed [CW-1:0]  first_y;
		logic [DW-1:0]         first_depth;
		logic signed [CW-1:0]  second_x;
		logic signed [CW-1:0]  second_y;
		logic [DW-1:0]         second_depth;
		logic signed [CW-1:0]  third_x;
		logic signed [CW-1:0]  third_y;
		logic [DW-1:0]         third_depth;
		logic [DW-1:0]         color;
	} req_word_t;

	typedef struct packed {
		logic [CNTW-1:0] pixels_written;
		logic [DW-1:0]   read_color;
		logic [DW-1:0]   read_depth;
	} rsp_word_t;

	typedef struct packed {
		logic            start;
		logic [NUMW-1:0] num;
		logic [DENW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [QW-1:0]   quo;
		logic [DENW-1:0] rem;
	} div_stat_t;

endpackage

>>> rtl/dtr_req_if.sv
interface dtr_req_if import dtr_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dtr_rsp_if.sv
interface dtr_rsp_if import dtr_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dtr_div.sv
module dtr_div import dtr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	logic [NUMW-1:0]      rem_q;
	logic [DENW-1:0]      den_q;
	logic [$clog2(QW)-1:0] k_q;
	logic [QW-1:0]        quo_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NUMW-1:0]      sh;
	logic                 ge;

	assign sh = {{(NUMW-DENW){1'b0}}, den_q} << k_q;
	assign ge = rem_q >= sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (k_q == '0);
			if (req.start) begin
				rem_q  <= req.num;
				den_q  <= req.den;
				k_q    <= '1;
				quo_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - sh;
				end
				quo_q[k_q] <= ge;
				k_q        <= k_q - 1'b1;
				if (k_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quo  = quo_q;
	assign stat.rem  = rem_q[DENW-1:0];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < {{(NUMW-DENW){1'b0}}, den_q})
		else $error("divider remainder not reduced");

endmodule

>>> rtl/depth_tested_line_triangle_raster_top.sv
// Line and triangle rasterizer with a depth test, drawing into one on-chip memory that
// holds color and depth for SCREEN_WIDTH x SCREEN_HEIGHT pixels. One request word at a time
// is taken and answered by one response word. After reset the block clears every pixel
// (depth 255, color 0) before it takes the first word. A line is set up with an 8-step divide
// for the depth slope, then walks its major axis: a step that falls off screen skips the
// memory, and an on-screen pixel takes one memory read and a write-back. A triangle is set up
// on one shared multiplier, then walks its bounding box: a pixel outside it skips the memory,
// and a covered pixel takes the 8-step depth divide (skipped for a zero-area triangle) plus the
// memory read-modify-write. A read skips the memory when the pixel is off screen.
// The memory has a single read and a single write port.
module depth_tested_line_triangle_raster_top import dtr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic clk,
	input  logic arst_n,
	dtr_req_if.sink   req,
	dtr_rsp_if.source rsp
);

	localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW  = $clog2(PIX);
	localparam logic signed [CW-1:0] WS = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] HS = CW'(SCREEN_HEIGHT);
	localparam logic [2*DW-1:0] CLEAR_WORD = {8'hFF, 8'h00};

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LSET, S_LDIV, S_LPIX, S_TCHK, S_TMUL, S_TFIN,
		S_TNORM, S_TPIX, S_TDIV, S_RCHK, S_RD, S_WR, S_ADV, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		MOP_DEN0, MOP_DEN1, MOP_NV0, MOP_NV1, MOP_NW0, MOP_NW1, MOP_EX0,
		MOP_EX1, MOP_EY0, MOP_EY1, MOP_E0, MOP_E1, MOP_BASE
	} mop_t;

	function automatic logic on_scr(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
		return (x >= 0) && (x < WS) && (y >= 0) && (y < HS);
	endfunction

	state_t    state_q;
	req_word_t cmd_q;
	rsp_word_t rsp_q;
	logic      rsp_valid_q;
	logic [AW-1:0]   clr_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rc_q, rdp_q, pd_q;
	logic signed [CW-1:0] px_q, py_q;
	logic [AW-1:0]   addr_q;

	// line walk
	logic                 xmaj_q, de_neg_q;
	logic signed [CW-1:0] a_q, b_q;
	logic [CW-1:0]        n_q, t_q, racc_b_q, rbs_q, racc_d_q, rds_q;
	logic signed [1:0]    qb_q;
	logic signed [9:0]    qd_q;
	logic [DW-1:0]        ld_q;

	// triangle walk
	mop_t m_q, pop_q;
	logic pvld_q;
	logic signed [35:0] prod_q;
	logic signed [23:0] den_q, pv_q, pw_q, pvr_q, pwr_q;
	logic signed [23:0] ivx_q, ivy_q, iwx_q, iwy_q;
	logic signed [31:0] e_q, er_q, ex_q, ey_q, base_q;

	// memory
	logic [2*DW-1:0] mem [PIX];
	logic [2*DW-1:0] mem_rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr, pix_addr;
	logic [2*DW-1:0] mem_wdata;

	div_req_t  dreq;
	div_stat_t dstat;

	dtr_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .stat(dstat));

	// line setup
	logic signed [CW:0]   ldx, ldy, adx, ady, ldb;
	logic                 xmaj, swap, single;
	logic signed [CW-1:0] sa0, sb0, sa1, sb1, la0, lb0, la1, lb1;
	logic [DW-1:0]        le0, le1;
	logic [CW-1:0]        ln;
	logic signed [DW:0]   lde;
	logic [DW-1:0]        lde_abs;
	logic signed [CW-1:0] lx, ly;

	assign ldx    = (CW+1)'(cmd_q.second_x) - (CW+1)'(cmd_q.first_x);
	assign ldy    = (CW+1)'(cmd_q.second_y) - (CW+1)'(cmd_q.first_y);
	assign adx    = ldx[CW] ? -ldx : ldx;
	assign ady    = ldy[CW] ? -ldy : ldy;
	assign xmaj   = adx > ady;
	assign single = (ldx == '0) && (ldy == '0);
	assign sa0 = xmaj ? cmd_q.first_x : cmd_q.first_y;
	assign sb0 = xmaj ? cmd_q.first_y : cmd_q.first_x;
	assign sa1 = xmaj ? cmd_q.second_x : cmd_q.second_y;
	assign sb1 = xmaj ? cmd_q.second_y : cmd_q.second_x;
	assign swap = sa0 > sa1;
	assign la0 = swap ? sa1 : sa0;
	assign lb0 = swap ? sb1 : sb0;
	assign la1 = swap ? sa0 : sa1;
	assign lb1 = swap ? sb0 : sb1;
	assign le0 = swap ? cmd_q.second_depth : cmd_q.first_depth;
	assign le1 = swap ? cmd_q.first_depth : cmd_q.second_depth;
	assign ln  = CW'((CW+1)'(la1) - (CW+1)'(la0));
	assign ldb = (CW+1)'(lb1) - (CW+1)'(lb0);
	assign lde = $signed({1'b0, le1}) - $signed({1'b0, le0});
	assign lde_abs = DW'(lde[DW] ? -lde : lde);
	assign lx = xmaj_q ? a_q : b_q;
	assign ly = xmaj_q ? b_q : a_q;

	// line step
	logic [CW:0]   sum_b, sum_d;
	logic          wrap_b, wrap_d;
	assign sum_b  = {1'b0, racc_b_q} + {1'b0, rbs_q};
	assign sum_d  = {1'b0, racc_d_q} + {1'b0, rds_q};
	assign wrap_b = sum_b >= {1'b0, n_q};
	assign wrap_d = sum_d >= {1'b0, n_q};

	// triangle setup
	logic signed [CW-1:0] minx, maxx, miny, maxy;
	logic signed [CW-1:0] v0x, v0y, v1x, v1y, ox, oy, qx, qy, dv, dw;
	logic signed [23:0]   mul_a;
	logic signed [11:0]   mul_b;
	logic                 tri_on, tneg;

	always_comb begin
		minx = cmd_q.first_x;
		if (cmd_q.second_x < minx) minx = cmd_q.second_x;
		if (cmd_q.third_x < minx) minx = cmd_q.third_x;
		maxx = cmd_q.first_x;
		if (cmd_q.second_x > maxx) maxx = cmd_q.second_x;
		if (cmd_q.third_x > maxx) maxx = cmd_q.third_x;
		miny = cmd_q.first_y;
		if (cmd_q.second_y < miny) miny = cmd_q.second_y;
		if (cmd_q.third_y < miny) miny = cmd_q.third_y;
		maxy = cmd_q.first_y;
		if (cmd_q.second_y > maxy) maxy = cmd_q.second_y;
		if (cmd_q.third_y > maxy) maxy = cmd_q.third_y;
	end

	assign v0x = cmd_q.second_x - cmd_q.first_x;
	assign v0y = cmd_q.second_y - cmd_q.first_y;
	assign v1x = cmd_q.third_x - cmd_q.first_x;
	assign v1y = cmd_q.third_y - cmd_q.first_y;
	assign ox  = minx - cmd_q.third_x;
	assign oy  = miny - cmd_q.third_y;
	assign qx  = minx - cmd_q.first_x;
	assign qy  = miny - cmd_q.first_y;
	assign dv  = $signed({4'b0, cmd_q.second_depth}) - $signed({4'b0, cmd_q.first_depth});
	assign dw  = $signed({4'b0, cmd_q.third_depth}) - $signed({4'b0, cmd_q.first_depth});
	assign tri_on = on_scr(cmd_q.first_x, cmd_q.first_y) &&
		on_scr(cmd_q.second_x, cmd_q.second_y) && on_scr(cmd_q.third_x, cmd_q.third_y);
	assign tneg = den_q[23];

	always_comb begin
		unique case (m_q)
			MOP_DEN0: begin mul_a = 24'(v0x); mul_b = v1y; end
			MOP_DEN1: begin mul_a = 24'(v0y); mul_b = v1x; end
			MOP_NV0:  begin mul_a = 24'(ox);  mul_b = v1y; end
			MOP_NV1:  begin mul_a = 24'(v1x); mul_b = oy;  end
			MOP_NW0:  begin mul_a = 24'(v0x); mul_b = qy;  end
			MOP_NW1:  begin mul_a = 24'(qx);  mul_b = v0y; end
			MOP_EX0:  begin mul_a = 24'(dv);  mul_b = v1y; end
			MOP_EX1:  begin mul_a = 24'(dw);  mul_b = v0y; end
			MOP_EY0:  begin mul_a = 24'(dw);  mul_b = v0x; end
			MOP_EY1:  begin mul_a = 24'(dv);  mul_b = v1x; end
			MOP_E0:   begin mul_a = pv_q;     mul_b = dv;  end
			MOP_E1:   begin mul_a = pw_q;     mul_b = dw;  end
			MOP_BASE: begin mul_a = den_q;    mul_b = $signed({4'b0, cmd_q.first_depth}); end
			default:  begin mul_a = '0;       mul_b = '0;  end
		endcase
	end

	// pixel coverage
	logic        zero_area, covered;
	logic [31:0] tnum;
	assign zero_area = den_q == '0;
	assign covered = zero_area ? (pv_q == '0 && pw_q == '0) :
		(!pv_q[23] && !pw_q[23] && (25'(pv_q) + 25'(pw_q) <= 25'(den_q)));
	assign tnum = 32'(base_q + e_q);

	// memory ports
	logic [DW-1:0] st_depth;
	logic          pass;
	assign pix_addr  = AW'(AW'(py_q) * AW'(SCREEN_WIDTH) + AW'(px_q));
	assign st_depth  = mem_rdata_q[2*DW-1:DW];
	assign pass      = (cmd_q.opcode == OPC_TRI) ? (pd_q < st_depth) : (pd_q <= st_depth);
	assign mem_we    = (state_q == S_CLEAR) ||
		(state_q == S_WR && cmd_q.opcode != OPC_READ && pass);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? CLEAR_WORD : {pd_q, cmd_q.color};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[pix_addr];
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = {{(NUMW-DW){1'b0}}, lde_abs};
		dreq.den   = {{(DENW-CW){1'b0}}, ln};
		if (state_q == S_LSET) begin
			dreq.start = !single;
		end else if (state_q == S_TPIX) begin
			dreq.start = covered && !zero_area;
			dreq.num   = tnum[NUMW-1:0];
			dreq.den   = den_q[DENW-1:0];
		end
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			pvld_q      <= 1'b0;
			m_q         <= MOP_DEN0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			pvld_q <= state_q == S_TMUL;
			pop_q  <= m_q;
			prod_q <= mul_a * mul_b;
			if (pvld_q) begin
				unique case (pop_q)
					MOP_DEN0: den_q  <= 24'(prod_q);
					MOP_DEN1: den_q  <= den_q - 24'(prod_q);
					MOP_NV0:  pv_q   <= 24'(prod_q);
					MOP_NV1:  pv_q   <= pv_q - 24'(prod_q);
					MOP_NW0:  pw_q   <= 24'(prod_q);
					MOP_NW1:  pw_q   <= pw_q - 24'(prod_q);
					MOP_EX0:  ex_q   <= 32'(prod_q);
					MOP_EX1:  ex_q   <= ex_q - 32'(prod_q);
					MOP_EY0:  ey_q   <= 32'(prod_q);
					MOP_EY1:  ey_q   <= ey_q - 32'(prod_q);
					MOP_E0:   e_q    <= 32'(prod_q);
					MOP_E1:   e_q    <= e_q + 32'(prod_q);
					MOP_BASE: base_q <= 32'(prod_q);
					default:  ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PIX - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.data;
						cnt_q <= '0;
						rc_q  <= '0;
						rdp_q <= '0;
						unique case (req.data.opcode)
							OPC_LINE: state_q <= S_LSET;
							OPC_TRI:  state_q <= S_TCHK;
							OPC_READ: state_q <= S_RCHK;
							OPC_NOP:  state_q <= S_DONE;
						endcase
					end
				end
				S_LSET: begin
					xmaj_q   <= xmaj;
					a_q      <= la0;
					b_q      <= lb0;
					ld_q     <= single ? ((cmd_q.first_depth < cmd_q.second_depth) ?
						cmd_q.first_depth : cmd_q.second_depth) : le0;
					n_q      <= ln;
					t_q      <= '0;
					racc_b_q <= '0;
					racc_d_q <= '0;
					de_neg_q <= lde[DW];
					qd_q     <= '0;
					rds_q    <= '0;
					if (!ldb[CW]) begin
						if (ldb == $signed({1'b0, ln})) begin
							qb_q  <= 2'sd1;
							rbs_q <= '0;
						end else begin
							qb_q  <= 2'sd0;
							rbs_q <= ldb[CW-1:0];
						end
					end else begin
						qb_q  <= -2'sd1;
						rbs_q <= CW'(ldb + $signed({1'b0, ln}));
					end
					state_q <= single ? S_LPIX : S_LDIV;
				end
				S_LDIV: begin
					if (dstat.done) begin
						if (!de_neg_q) begin
							qd_q  <= $signed({2'b0, dstat.quo});
							rds_q <= dstat.rem[CW-1:0];
						end else if (dstat.rem == '0) begin
							qd_q  <= -$signed({2'b0, dstat.quo});
							rds_q <= '0;
						end else begin
							qd_q  <= -$signed({2'b0, dstat.quo}) - 10'sd1;
							rds_q <= n_q - dstat.rem[CW-1:0];
						end
						state_q <= S_LPIX;
					end
				end
				S_LPIX: begin
					px_q <= lx;
					py_q <= ly;
					pd_q <= ld_q;
					state_q <= on_scr(lx, ly) ? S_RD : S_ADV;
				end
				S_TCHK: begin
					m_q     <= MOP_DEN0;
					state_q <= tri_on ? S_TMUL : S_DONE;
				end
				S_TMUL: begin
					if (m_q == MOP_BASE) begin
						state_q <= S_TFIN;
					end else begin
						m_q <= mop_t'(m_q + 4'd1);
					end
				end
				S_TFIN: begin
					state_q <= S_TNORM;
				end
				S_TNORM: begin
					den_q  <= tneg ? -den_q : den_q;
					pv_q   <= tneg ? -pv_q : pv_q;
					pvr_q  <= tneg ? -pv_q : pv_q;
					pw_q   <= tneg ? -pw_q : pw_q;
					pwr_q  <= tneg ? -pw_q : pw_q;
					e_q    <= tneg ? -e_q : e_q;
					er_q   <= tneg ? -e_q : e_q;
					ex_q   <= tneg ? -ex_q : ex_q;
					ey_q   <= tneg ? -ey_q : ey_q;
					base_q <= tneg ? -base_q : base_q;
					ivx_q  <= tneg ? -24'(v1y) : 24'(v1y);
					ivy_q  <= tneg ? 24'(v1x) : -24'(v1x);
					iwx_q  <= tneg ? 24'(v0y) : -24'(v0y);
					iwy_q  <= tneg ? -24'(v0x) : 24'(v0x);
					px_q   <= minx;
					py_q   <= miny;
					state_q <= S_TPIX;
				end
				S_TPIX: begin
					if (!covered) begin
						state_q <= S_ADV;
					end else if (zero_area) begin
						pd_q    <= cmd_q.first_depth;
						state_q <= S_RD;
					end else begin
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (dstat.done) begin
						pd_q    <= dstat.quo;
						state_q <= S_RD;
					end
				end
				S_RCHK: begin
					px_q <= cmd_q.first_x;
					py_q <= cmd_q.first_y;
					state_q <= on_scr(cmd_q.first_x, cmd_q.first_y) ? S_RD : S_DONE;
				end
				S_RD: begin
					addr_q  <= pix_addr;
					state_q <= S_WR;
				end
				S_WR: begin
					if (cmd_q.opcode == OPC_READ) begin
						rc_q    <= mem_rdata_q[DW-1:0];
						rdp_q   <= st_depth;
						state_q <= S_DONE;
					end else begin
						if (pass) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (cmd_q.opcode == OPC_LINE) begin
						if (t_q == n_q) begin
							state_q <= S_DONE;
						end else begin
							t_q      <= t_q + 1'b1;
							a_q      <= a_q + 1'b1;
							racc_b_q <= wrap_b ? CW'(sum_b - {1'b0, n_q}) : sum_b[CW-1:0];
							racc_d_q <= wrap_d ? CW'(sum_d - {1'b0, n_q}) : sum_d[CW-1:0];
							b_q  <= CW'(b_q + CW'(qb_q) + {{(CW-1){1'b0}}, wrap_b});
							ld_q <= DW'($signed({2'b0, ld_q}) + qd_q + $signed({9'b0, wrap_d}));
							state_q <= S_LPIX;
						end
					end else begin
						if (px_q == maxx) begin
							if (py_q == maxy) begin
								state_q <= S_DONE;
							end else begin
								py_q  <= py_q + 1'b1;
								px_q  <= minx;
								pvr_q <= pvr_q + ivy_q;
								pv_q  <= pvr_q + ivy_q;
								pwr_q <= pwr_q + iwy_q;
								pw_q  <= pwr_q + iwy_q;
								er_q  <= er_q + ey_q;
								e_q   <= er_q + ey_q;
								state_q <= S_TPIX;
							end
						end else begin
							px_q <= px_q + 1'b1;
							pv_q <= pv_q + ivx_q;
							pw_q <= pw_q + iwx_q;
							e_q  <= e_q + ex_q;
							state_q <= S_TPIX;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q.pixels_written <= cnt_q;
						rsp_q.read_color     <= rc_q;
						rsp_q.read_depth     <= rdp_q;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_line_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADV && cmd_q.opcode == OPC_LINE && n_q != '0) |->
		(racc_b_q < n_q && racc_d_q < n_q)) else $error("line remainder out of range");
	a_den_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TPIX |-> !den_q[23]) else $error("triangle area not normalized");
	a_wr_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_RD) else $error("write-back without read");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("memory written outside a draw");

endmodule
